/* hdl/urtb_pkg.sv */
// Shared types, constants and pointer helpers for the UART ring buffer pair.
package urtb_pkg;

  localparam int FIFO_DEPTH = 256;
  localparam int ADDR_W     = $clog2(FIFO_DEPTH);
  localparam int PTR_SPAN   = 2 * FIFO_DEPTH;
  localparam int PTR_W      = $clog2(PTR_SPAN);
  localparam int LVL_W      = 9;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef enum logic [1:0] {
    MODE_RX,
    MODE_GET,
    MODE_PUT,
    MODE_TXRDY
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] data_byte;
    logic       parity_ok;
  } in_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             accepted;
    logic             tx_request;
    logic [LVL_W-1:0] rx_level;
    logic [LVL_W-1:0] tx_level;
  } out_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(PTR_SPAN - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] fifo_level(input logic [PTR_W-1:0] rd,
                                                  input logic [PTR_W-1:0] wr);
    logic [PTR_W:0] wrap;
    wrap = {1'b0, wr} + (PTR_W + 1)'(PTR_SPAN) - {1'b0, rd};
    return (wr >= rd) ? (wr - rd) : wrap[PTR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] slot_of(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] s;
    s = (p >= PTR_W'(FIFO_DEPTH)) ? (p - PTR_W'(FIFO_DEPTH)) : p;
    return s[ADDR_W-1:0];
  endfunction

endpackage

/* hdl/urtb_ram.sv */
// Simple dual-port byte RAM with one write port and one registered read port.
module urtb_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/urtb_ctrl.sv */
// Request sequencer: FIFO pointers, transmit request flag, RAM access and response register.
module urtb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  urtb_pkg::in_t       req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output urtb_pkg::out_t      rsp,
  output urtb_pkg::ram_req_t  rx_ram,
  output urtb_pkg::ram_req_t  tx_ram,
  input  logic [7:0]          rx_rd_data,
  input  logic [7:0]          tx_rd_data
);

  urtb_pkg::state_t                 state, state_next;
  logic [urtb_pkg::PTR_W-1:0]       rx_rp, rx_rp_next, rx_wp, rx_wp_next;
  logic [urtb_pkg::PTR_W-1:0]       tx_rp, tx_rp_next, tx_wp, tx_wp_next;
  logic [urtb_pkg::PTR_W-1:0]       rx_lvl, tx_lvl, tx_wp_cr;
  logic                             flag, flag_next;
  urtb_pkg::out_t                   pend, pend_next;
  logic                             pend_rx, pend_rx_next, pend_tx, pend_tx_next;
  logic                             lf_pend, lf_pend_next;
  logic [urtb_pkg::ADDR_W-1:0]      lf_addr, lf_addr_next;
  urtb_pkg::out_t                   rsp_next;
  logic                             rsp_valid_next;
  logic                             slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= urtb_pkg::ST_IDLE;
      rx_rp     <= '0;
      rx_wp     <= '0;
      tx_rp     <= '0;
      tx_wp     <= '0;
      flag      <= 1'b0;
      pend_rx   <= 1'b0;
      pend_tx   <= 1'b0;
      lf_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rx_rp     <= rx_rp_next;
      rx_wp     <= rx_wp_next;
      tx_rp     <= tx_rp_next;
      tx_wp     <= tx_wp_next;
      flag      <= flag_next;
      pend_rx   <= pend_rx_next;
      pend_tx   <= pend_tx_next;
      lf_pend   <= lf_pend_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend    <= pend_next;
    lf_addr <= lf_addr_next;
    rsp     <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    rx_rp_next     = rx_rp;
    rx_wp_next     = rx_wp;
    tx_rp_next     = tx_rp;
    tx_wp_next     = tx_wp;
    flag_next      = flag;
    pend_next      = pend;
    pend_rx_next   = pend_rx;
    pend_tx_next   = pend_tx;
    lf_pend_next   = lf_pend;
    lf_addr_next   = lf_addr;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && rsp_stall;
    rx_ram         = '0;
    tx_ram         = '0;
    req_stall      = (state != urtb_pkg::ST_IDLE);
    slot_free      = !rsp_valid || !rsp_stall;
    rx_lvl         = urtb_pkg::fifo_level(rx_rp, rx_wp);
    tx_lvl         = urtb_pkg::fifo_level(tx_rp, tx_wp);
    tx_wp_cr       = urtb_pkg::ptr_next(tx_wp);

    unique case (state)
      urtb_pkg::ST_IDLE: begin
        if (req_valid) begin
          pend_next    = '0;
          pend_rx_next = 1'b0;
          pend_tx_next = 1'b0;
          lf_pend_next = 1'b0;
          unique case (req.mode)
            urtb_pkg::MODE_RX: begin
              if (req.parity_ok && rx_lvl < urtb_pkg::PTR_W'(urtb_pkg::FIFO_DEPTH)) begin
                rx_ram.wr_en       = 1'b1;
                rx_ram.wr_addr     = urtb_pkg::slot_of(rx_wp);
                rx_ram.wr_data     = req.data_byte;
                rx_wp_next         = urtb_pkg::ptr_next(rx_wp);
                pend_next.accepted = 1'b1;
              end
            end
            urtb_pkg::MODE_GET: begin
              if (rx_lvl == '0) begin
                rx_rp_next = '0;
                rx_wp_next = '0;
              end else begin
                rx_ram.rd_en         = 1'b1;
                rx_ram.rd_addr       = urtb_pkg::slot_of(rx_rp);
                rx_rp_next           = urtb_pkg::ptr_next(rx_rp);
                pend_next.byte_valid = 1'b1;
                pend_rx_next         = 1'b1;
              end
            end
            urtb_pkg::MODE_PUT: begin
              if (tx_lvl < urtb_pkg::PTR_W'(urtb_pkg::FIFO_DEPTH)) begin
                tx_ram.wr_en   = 1'b1;
                tx_ram.wr_addr = urtb_pkg::slot_of(tx_wp);
                flag_next      = 1'b1;
                if (req.data_byte == urtb_pkg::CHAR_LF) begin
                  // push carriage return now, line feed next cycle if room
                  tx_ram.wr_data = urtb_pkg::CHAR_CR;
                  tx_wp_next     = tx_wp_cr;
                  if (tx_lvl < urtb_pkg::PTR_W'(urtb_pkg::FIFO_DEPTH - 1)) begin
                    lf_pend_next       = 1'b1;
                    lf_addr_next       = urtb_pkg::slot_of(tx_wp_cr);
                    tx_wp_next         = urtb_pkg::ptr_next(tx_wp_cr);
                    pend_next.accepted = 1'b1;
                  end
                end else begin
                  tx_ram.wr_data     = req.data_byte;
                  tx_wp_next         = tx_wp_cr;
                  pend_next.accepted = 1'b1;
                end
              end
            end
            urtb_pkg::MODE_TXRDY: begin
              if (tx_lvl == '0) begin
                flag_next  = 1'b0;
                tx_rp_next = '0;
                tx_wp_next = '0;
              end else begin
                tx_ram.rd_en         = 1'b1;
                tx_ram.rd_addr       = urtb_pkg::slot_of(tx_rp);
                tx_rp_next           = urtb_pkg::ptr_next(tx_rp);
                pend_next.byte_valid = 1'b1;
                pend_tx_next         = 1'b1;
              end
            end
            default: ;
          endcase
          pend_next.tx_request = flag_next;
          pend_next.rx_level   = urtb_pkg::LVL_W'(urtb_pkg::fifo_level(rx_rp_next, rx_wp_next));
          pend_next.tx_level   = urtb_pkg::LVL_W'(urtb_pkg::fifo_level(tx_rp_next, tx_wp_next));
          state_next           = urtb_pkg::ST_FIN;
        end
      end
      urtb_pkg::ST_FIN: begin
        if (lf_pend) begin
          tx_ram.wr_en   = 1'b1;
          tx_ram.wr_addr = lf_addr;
          tx_ram.wr_data = urtb_pkg::CHAR_LF;
        end
        lf_pend_next = 1'b0;
        if (pend_rx) begin
          pend_next.out_byte = rx_rd_data;
        end else if (pend_tx) begin
          pend_next.out_byte = tx_rd_data;
        end
        pend_rx_next = 1'b0;
        pend_tx_next = 1'b0;
        if (slot_free) begin
          rsp_next       = pend_next;
          rsp_valid_next = 1'b1;
          state_next     = urtb_pkg::ST_IDLE;
        end else begin
          state_next = urtb_pkg::ST_HOLD;
        end
      end
      urtb_pkg::ST_HOLD: begin
        if (slot_free) begin
          rsp_next       = pend;
          rsp_valid_next = 1'b1;
          state_next     = urtb_pkg::ST_IDLE;
        end
      end
      default: state_next = urtb_pkg::ST_IDLE;
    endcase
  end

endmodule

/* hdl/uart_rx_tx_ring_buffers_core.sv */
// Top level of the UART receive/transmit ring buffer pair.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | urtb_pkg::in_t  (mode, data_byte, parity_ok)
//   rsp     | out       | rsp_valid / rsp_stall  | urtb_pkg::out_t (byte, flags, levels)
//
// Each request is accepted in the idle state, which issues the RAM read or write; the finish
// state folds in read data (and writes the line feed) and loads the response register. A new
// request is taken only once the last has loaded its response, also while a response waits.
// Synchronous reset clears all pointers and the request flag; the RAMs need no clearing.
// A stalled response holds the sequencer in its hold state until it drains.
module uart_rx_tx_ring_buffers_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  urtb_pkg::in_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output urtb_pkg::out_t rsp
);

  urtb_pkg::ram_req_t rx_ram, tx_ram;
  logic [7:0]         rx_rd_data, tx_rd_data;

  urtb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .rx_ram     (rx_ram),
    .tx_ram     (tx_ram),
    .rx_rd_data (rx_rd_data),
    .tx_rd_data (tx_rd_data)
  );

  urtb_ram #(
    .DEPTH (urtb_pkg::FIFO_DEPTH),
    .WIDTH (8)
  ) u_rx_ram (
    .clk     (clk),
    .wr_en   (rx_ram.wr_en),
    .wr_addr (rx_ram.wr_addr),
    .wr_data (rx_ram.wr_data),
    .rd_en   (rx_ram.rd_en),
    .rd_addr (rx_ram.rd_addr),
    .rd_data (rx_rd_data)
  );

  urtb_ram #(
    .DEPTH (urtb_pkg::FIFO_DEPTH),
    .WIDTH (8)
  ) u_tx_ram (
    .clk     (clk),
    .wr_en   (tx_ram.wr_en),
    .wr_addr (tx_ram.wr_addr),
    .wr_data (tx_ram.wr_data),
    .rd_en   (tx_ram.rd_en),
    .rd_addr (tx_ram.rd_addr),
    .rd_data (tx_rd_data)
  );

endmodule

/* hdl/urtb_chk.sv */
// Port-level checker for the UART ring buffer pair, bound to the top level.
module urtb_chk (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input urtb_pkg::out_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp))
    else $error("stalled response changed");

  a_pop_push_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.byte_valid && rsp.accepted))
    else $error("response both popped and stored a byte");

  a_empty_byte: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.byte_valid |-> rsp.out_byte == 8'h00)
    else $error("byte without pop is not zero");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.rx_level <= urtb_pkg::LVL_W'(urtb_pkg::FIFO_DEPTH) &&
                  rsp.tx_level <= urtb_pkg::LVL_W'(urtb_pkg::FIFO_DEPTH))
    else $error("FIFO level out of range");

endmodule

bind uart_rx_tx_ring_buffers_core urtb_chk u_urtb_chk (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

/* test/tb_uart_rx_tx_ring_buffers_core.sv */
// Self-checking testbench for the UART receive/transmit ring buffer pair.
module tb_uart_rx_tx_ring_buffers_core;
  import urtb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int QUIET_TAIL  = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  in_t  req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  out_t rsp;

  in_t  host_line_q[$];
  out_t ring_out_q[$];

  logic [7:0]       rx_mem [FIFO_DEPTH];
  logic [7:0]       tx_mem [FIFO_DEPTH];
  logic [PTR_W-1:0] rx_rd = '0;
  logic [PTR_W-1:0] rx_wr = '0;
  logic [PTR_W-1:0] tx_rd = '0;
  logic [PTR_W-1:0] tx_wr = '0;
  logic             tx_flag = 1'b0;

  int total_items = 0;
  int sent_cnt = 0;
  int got_cnt = 0;
  int miss_cnt = 0;
  int cycle_cnt = 0;
  int send_gap = 0;
  int hold_left = 0;
  bit held_once = 1'b0;
  int rx_full_drops = 0;
  int tx_full_refusals = 0;

  uart_rx_tx_ring_buffers_core DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [LVL_W-1:0] occupancy(input logic [PTR_W-1:0] rd,
                                                 input logic [PTR_W-1:0] wr);
    return LVL_W'(wr - rd);
  endfunction

  function logic tx_append(input logic [7:0] b);
    if (occupancy(tx_rd, tx_wr) >= FIFO_DEPTH) return 1'b0;
    tx_mem[tx_wr[ADDR_W-1:0]] = b;
    tx_wr = tx_wr + 1'b1;
    tx_flag = 1'b1;
    return 1'b1;
  endfunction

  function out_t ring_step(input in_t r);
    out_t o;
    logic ok;
    o = '0;
    case (r.mode)
      MODE_RX: begin
        if (r.parity_ok && occupancy(rx_rd, rx_wr) < FIFO_DEPTH) begin
          rx_mem[rx_wr[ADDR_W-1:0]] = r.data_byte;
          rx_wr = rx_wr + 1'b1;
          o.accepted = 1'b1;
        end else if (r.parity_ok) begin
          rx_full_drops++;
        end
      end
      MODE_GET: begin
        if (occupancy(rx_rd, rx_wr) == 0) begin
          rx_rd = '0;
          rx_wr = '0;
        end else begin
          o.out_byte = rx_mem[rx_rd[ADDR_W-1:0]];
          o.byte_valid = 1'b1;
          rx_rd = rx_rd + 1'b1;
        end
      end
      MODE_PUT: begin
        ok = 1'b1;
        if (r.data_byte == CHAR_LF) ok = tx_append(CHAR_CR);
        if (ok) ok = tx_append(r.data_byte);
        if (!ok) tx_full_refusals++;
        o.accepted = ok;
      end
      default: begin
        if (occupancy(tx_rd, tx_wr) == 0) begin
          tx_flag = 1'b0;
          tx_rd = '0;
          tx_wr = '0;
        end else begin
          o.out_byte = tx_mem[tx_rd[ADDR_W-1:0]];
          o.byte_valid = 1'b1;
          tx_rd = tx_rd + 1'b1;
        end
      end
    endcase
    o.tx_request = tx_flag;
    o.rx_level = occupancy(rx_rd, rx_wr);
    o.tx_level = occupancy(tx_rd, tx_wr);
    return o;
  endfunction

  task automatic queue_req(input mode_t m, input logic [7:0] d, input logic p);
    in_t r;
    r.mode = m;
    r.data_byte = d;
    r.parity_ok = p;
    host_line_q.push_back(r);
  endtask

  task automatic queue_random(input int n, input int w_rx, input int w_get, input int w_put,
                              input int w_rdy, input int lf_pct);
    int pick;
    mode_t m;
    logic [7:0] d;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, w_rx + w_get + w_put + w_rdy - 1);
      if (pick < w_rx) m = MODE_RX;
      else if (pick < w_rx + w_get) m = MODE_GET;
      else if (pick < w_rx + w_get + w_put) m = MODE_PUT;
      else m = MODE_TXRDY;
      d = 8'($urandom_range(0, 255));
      if (m == MODE_PUT && $urandom_range(0, 99) < lf_pct) d = CHAR_LF;
      queue_req(m, d, $urandom_range(0, 19) != 0);
    end
  endtask

  task automatic log_miss(input string what);
    miss_cnt++;
    if (miss_cnt <= 10) $display("mismatch at response %0d: %s", got_cnt, what);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_valid && !req_stall) begin
        ring_out_q.push_back(ring_step(req));
        sent_cnt++;
      end
      if (!req_valid || !req_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (host_line_q.size() == 0) begin
          req_valid <= 1'b0;
        end else if (sent_cnt < total_items - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 10) - 1;
          req_valid <= 1'b0;
        end else begin
          req <= host_line_q.pop_front();
          req_valid <= 1'b1;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (ring_out_q.size() == 0) begin
          log_miss($sformatf("unexpected response %p", rsp));
        end else begin
          want = ring_out_q.pop_front();
          if (rsp.out_byte !== want.out_byte)
            log_miss($sformatf("out_byte exp %0h got %0h", want.out_byte, rsp.out_byte));
          if (rsp.byte_valid !== want.byte_valid)
            log_miss($sformatf("byte_valid exp %0b got %0b", want.byte_valid, rsp.byte_valid));
          if (rsp.accepted !== want.accepted)
            log_miss($sformatf("accepted exp %0b got %0b", want.accepted, rsp.accepted));
          if (rsp.tx_request !== want.tx_request)
            log_miss($sformatf("tx_request exp %0b got %0b", want.tx_request, rsp.tx_request));
          if (rsp.rx_level !== want.rx_level)
            log_miss($sformatf("rx_level exp %0d got %0d", want.rx_level, rsp.rx_level));
          if (rsp.tx_level !== want.tx_level)
            log_miss($sformatf("tx_level exp %0d got %0d", want.tx_level, rsp.tx_level));
        end
        got_cnt++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (!held_once && got_cnt >= 100) begin
        // hold off long enough to back up the request side
        held_once = 1'b1;
        hold_left = 59;
        rsp_stall <= 1'b1;
      end else if (sent_cnt < total_items - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 10) - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_cnt,
               ring_out_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    queue_req(MODE_GET, 8'h00, 1'b1);
    queue_req(MODE_TXRDY, 8'hFF, 1'b0);
    queue_req(MODE_RX, 8'h00, 1'b1);
    queue_req(MODE_RX, 8'hFF, 1'b1);
    queue_req(MODE_RX, 8'hA5, 1'b0);
    queue_req(MODE_RX, 8'h5A, 1'b1);
    queue_req(MODE_RX, CHAR_LF, 1'b1);
    queue_req(MODE_GET, 8'hFF, 1'b0);
    queue_req(MODE_GET, 8'h00, 1'b1);
    queue_req(MODE_GET, 8'h33, 1'b0);
    queue_req(MODE_GET, 8'hCC, 1'b1);
    queue_req(MODE_GET, 8'h00, 1'b1);
    queue_req(MODE_PUT, 8'h00, 1'b0);
    queue_req(MODE_PUT, 8'hFF, 1'b1);
    queue_req(MODE_PUT, CHAR_LF, 1'b1);
    queue_req(MODE_PUT, CHAR_CR, 1'b0);
    queue_req(MODE_TXRDY, 8'h00, 1'b1);
    queue_req(MODE_TXRDY, 8'hFF, 1'b0);
    queue_req(MODE_TXRDY, 8'h81, 1'b1);
    queue_req(MODE_TXRDY, 8'h7E, 1'b0);
    queue_req(MODE_TXRDY, 8'h00, 1'b1);
    queue_req(MODE_TXRDY, 8'h00, 1'b1);
    queue_req(MODE_PUT, 8'h5A, 1'b0);
    // mixed traffic, then fill the rx side, fill the tx side, and drain
    queue_random(60, 25, 25, 25, 25, 20);
    queue_random(320, 96, 2, 1, 1, 20);
    queue_random(220, 2, 2, 94, 2, 50);
    queue_random(150, 30, 35, 5, 30, 20);
    total_items = host_line_q.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (sent_cnt < total_items) @(posedge clk);
    while (ring_out_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d requests driven, %0d responses checked, %0d mismatches",
             sent_cnt, got_cnt, miss_cnt);
    $display("%0d line bytes dropped on a full rx buffer, %0d puts refused on a full tx buffer",
             rx_full_drops, tx_full_refusals);
    if (miss_cnt == 0 && ring_out_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/urtb_pkg.sv
hdl/urtb_ram.sv
hdl/urtb_ctrl.sv
hdl/uart_rx_tx_ring_buffers_core.sv
hdl/urtb_chk.sv
test/tb_uart_rx_tx_ring_buffers_core.sv
